// File: hw/rtl/tte_pkg.sv
// Shared types, constants and rounding helpers of the tether tension estimator.
// No dependencies; every other RTL file imports this package.
package tte_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAC_A_W   = 44;
    localparam int MAC_B_W   = 22;
    localparam int MAC_P_W   = 68;

    localparam logic signed [20:0] PI_F       = 21'sd205887;
    localparam logic signed [20:0] HALF_PI_F  = 21'sd102944;
    localparam logic signed [20:0] NHALF_PI_F = -21'sd102944;
    localparam logic signed [19:0] GAIN_F     = 20'sd39797;

    localparam logic [24:0] POLY_C2 = 25'd24560629;
    localparam logic [43:0] POLY_C1 = 44'd1190544792000;
    localparam logic [60:0] POLY_C0 = 61'd632326716600000;
    localparam logic [60:0] FP_HALF = 61'd8796093022208;

    localparam logic [19:0] OUT_LIMIT  = 20'hFFFFF;
    localparam logic [20:0] COMP_LIMIT = 21'h100000;
    localparam logic [16:0] ONE_F      = 17'h10000;
    localparam logic [31:0] COV_RESET  = 32'h10000;

    localparam logic [1:0] CFG_MASS   = 2'd0;
    localparam logic [1:0] CFG_QNOISE = 2'd1;
    localparam logic [1:0] CFG_RNOISE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG,
        ST_PREP,
        ST_COMP,
        ST_SQUARE,
        ST_ROOT,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                      en;
        logic                      acc;
        logic signed [MAC_A_W-1:0] a;
        logic signed [MAC_B_W-1:0] b;
    } mac_req_t;

    function automatic logic [15:0] atan_f(input logic [3:0] i);
        logic [15:0] v;
        unique case (i)
            4'd0:  v = 16'd51472;
            4'd1:  v = 16'd30386;
            4'd2:  v = 16'd16055;
            4'd3:  v = 16'd8150;
            4'd4:  v = 16'd4091;
            4'd5:  v = 16'd2047;
            4'd6:  v = 16'd1024;
            4'd7:  v = 16'd512;
            4'd8:  v = 16'd256;
            4'd9:  v = 16'd128;
            4'd10: v = 16'd64;
            4'd11: v = 16'd32;
            4'd12: v = 16'd16;
            4'd13: v = 16'd8;
            4'd14: v = 16'd4;
            4'd15: v = 16'd2;
        endcase
        return v;
    endfunction

    function automatic logic signed [51:0] rnd16(input logic signed [MAC_P_W-1:0] v);
        logic signed [MAC_P_W-1:0] t;
        t = v + 68'sd32768;
        return t[67:16];
    endfunction

    function automatic logic signed [27:0] rnd12(input logic signed [MAC_P_W-1:0] v);
        logic signed [MAC_P_W-1:0] t;
        t = v + 68'sd2048;
        return t[39:12];
    endfunction

    function automatic logic signed [27:0] rnd20(input logic signed [MAC_P_W-1:0] v);
        logic signed [MAC_P_W-1:0] t;
        t = v + 68'sd524288;
        return t[47:20];
    endfunction

endpackage

// File: hw/rtl/tether_tension_estimator_unit.sv
// Top level of the tether tension estimator: sequencer, shared MAC and iterative units.
// Depends on tte_pkg, tte_mac, tte_cordic, tte_sqrt and tte_div.
//
// Usage:
//   Input channel (in_valid/in_stall): one request carries three angles, three body
//   accelerations and four motor PWM words. in_stall is high from the cycle after a
//   request is taken until its result has been loaded into the output register.
//   Output channel (out_valid/out_stall): one result per request, raw and Kalman
//   filtered tension. The result register holds while out_stall is high; the
//   sequencer waits in its last step while the register is full and stalled.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write only while idle.
//   Sequence from accept to out_valid: three CORDIC runs, shared-multiplier steps
//   for thrust and rotation, then for the three tension components, the squares,
//   the root and the filter update, and last the load of the result. The gain
//   divider runs alongside the CORDIC.
//   One request is processed at a time on the single multiplier and the CORDIC loop;
//   the next is taken after the result is loaded, later while the output is stalled.
//   Reset: control and config registers return to defaults, estimate is zero, covariance is one.
module tether_tension_estimator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [14:0] roll_angle,
    input  logic [14:0] pitch_angle,
    input  logic [14:0] yaw_angle,
    input  logic [20:0] accel_x,
    input  logic [20:0] accel_y,
    input  logic [20:0] accel_z,
    input  logic [15:0] pwm_motor_one,
    input  logic [15:0] pwm_motor_two,
    input  logic [15:0] pwm_motor_three,
    input  logic [15:0] pwm_motor_four,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [19:0] raw_tension,
    output logic [19:0] filtered_tension,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import tte_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic [4:0] step_reg;
    logic [4:0] step_next;
    logic       launch_reg;
    logic       launch_next;
    logic [1:0] comp_idx_reg;
    logic [1:0] comp_idx_next;

    logic [19:0] mass_reg;
    logic [19:0] qnoise_reg;
    logic [19:0] rnoise_reg;
    logic [19:0] est_reg;
    logic [31:0] cov_reg;
    logic        out_valid_reg;
    logic [19:0] raw_out_reg;
    logic [19:0] filt_out_reg;

    logic signed [14:0] roll_reg;
    logic signed [14:0] pitch_reg;
    logic signed [14:0] yaw_reg;
    logic signed [20:0] acx_reg;
    logic signed [20:0] acy_reg;
    logic signed [20:0] acz_reg;
    logic [15:0] pwm0_reg;
    logic [15:0] pwm1_reg;
    logic [15:0] pwm2_reg;
    logic [15:0] pwm3_reg;
    logic signed [19:0] sr_reg;
    logic signed [19:0] cr_reg;
    logic signed [19:0] sp_reg;
    logic signed [19:0] cp_reg;
    logic signed [19:0] sy_reg;
    logic signed [19:0] cy_reg;
    logic signed [19:0] cysp_reg;
    logic signed [19:0] sysp_reg;
    logic signed [19:0] ma_reg;
    logic signed [19:0] mb_reg;
    logic signed [19:0] mc_reg;
    logic signed [19:0] md_reg;
    logic signed [19:0] me_reg;
    logic signed [19:0] mf_reg;
    logic signed [19:0] mh_reg;
    logic signed [19:0] mi_reg;
    logic [60:0] sum_reg;
    logic signed [27:0] dot_reg;
    logic signed [29:0] tf_reg;
    logic [20:0] t0_reg;
    logic [20:0] t1_reg;
    logic [20:0] t2_reg;
    logic [19:0] raw_reg;
    logic [32:0] pp_reg;
    logic [33:0] den_reg;

    mac_req_t                  mreq;
    logic signed [MAC_P_W-1:0] mac_acc;
    logic signed [51:0]        p16;
    logic signed [43:0]        fa;
    logic [60:0]               fp_sum;
    logic [16:0]               fp_w;
    logic [15:0]               pwm_sel;
    logic signed [19:0]        opx;
    logic signed [19:0]        opy;
    logic signed [19:0]        r0;
    logic signed [19:0]        r1;
    logic signed [19:0]        r2;
    logic signed [19:0]        rz;
    logic signed [27:0]        tm_w;
    logic signed [29:0]        tdiff;
    logic [29:0]               tabs;
    logic [20:0]               tclamp;
    logic [32:0]               pp_w;
    logic [33:0]               den_w;
    logic [16:0]               k_w;
    logic [16:0]               omk_w;
    logic signed [20:0]        diff_w;
    logic signed [22:0]        est_sum;
    logic [19:0]               est_new;
    logic [31:0]               cov_new;
    logic [20:0]               lead_w;

    logic               in_accept;
    logic               out_load;
    logic               cordic_start;
    logic               cordic_done;
    logic signed [14:0] cordic_angle;
    logic signed [19:0] cordic_sin;
    logic signed [19:0] cordic_cos;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [20:0]        sqrt_root;
    logic               div_busy;
    logic [16:0]        div_quo;

    tte_mac u_mac (
        .clk (clk),
        .req (mreq),
        .acc (mac_acc)
    );

    tte_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .sin_val (cordic_sin),
        .cos_val (cordic_cos)
    );

    tte_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (mac_acc[41:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    tte_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept),
        .num   (pp_w),
        .den   (den_w),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign in_stall         = (state_reg != ST_IDLE);
    assign in_accept        = in_valid && !in_stall;
    assign out_valid        = out_valid_reg;
    assign raw_tension      = raw_out_reg;
    assign filtered_tension = filt_out_reg;
    assign cfg_ready        = 1'b1;
    assign out_load         = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        p16     = rnd16(mac_acc);
        fa      = mac_acc[43:0] + POLY_C1;
        fp_sum  = sum_reg + FP_HALF;
        fp_w    = fp_sum[60:44];
        pp_w    = {1'b0, cov_reg} + {5'b0, qnoise_reg, 8'b0};
        den_w   = {1'b0, pp_w} + {6'b0, rnoise_reg, 8'b0};
        k_w     = (den_reg == '0) ? '0 : div_quo;
        omk_w   = ONE_F - k_w;
        diff_w  = $signed({1'b0, raw_reg}) - $signed({1'b0, est_reg});
        est_sum = $signed({3'b000, est_reg}) + p16[22:0];
        if (est_sum[22])
        begin
            est_new = '0;
        end
        else if (est_sum[21:20] != 2'b00)
        begin
            est_new = OUT_LIMIT;
        end
        else
        begin
            est_new = est_sum[19:0];
        end
        cov_new = (p16[51:32] != '0) ? 32'hFFFF_FFFF : p16[31:0];
        tm_w    = rnd20(mac_acc);
        tdiff   = tf_reg - 30'(tm_w);
        tabs    = tdiff[29] ? 30'(-tdiff) : tdiff;
        tclamp  = (tabs > 30'(COMP_LIMIT)) ? COMP_LIMIT : tabs[20:0];
        lead_w  = sqrt_root;
    end

    always_comb
    begin
        unique case (step_reg[2:1])
            2'd0: pwm_sel = pwm0_reg;
            2'd1: pwm_sel = pwm1_reg;
            2'd2: pwm_sel = pwm2_reg;
            2'd3: pwm_sel = pwm3_reg;
        endcase
        unique case (step_reg[1:0])
            2'd0:    cordic_angle = roll_reg;
            2'd1:    cordic_angle = pitch_reg;
            default: cordic_angle = yaw_reg;
        endcase
        case (step_reg)
            5'd8:    begin opx = cy_reg;   opy = sp_reg; end
            5'd9:    begin opx = sy_reg;   opy = sp_reg; end
            5'd10:   begin opx = cy_reg;   opy = cp_reg; end
            5'd11:   begin opx = sy_reg;   opy = cr_reg; end
            5'd12:   begin opx = cysp_reg; opy = sr_reg; end
            5'd13:   begin opx = sy_reg;   opy = sr_reg; end
            5'd14:   begin opx = cysp_reg; opy = cr_reg; end
            5'd15:   begin opx = sy_reg;   opy = cp_reg; end
            5'd16:   begin opx = cy_reg;   opy = cr_reg; end
            5'd17:   begin opx = sysp_reg; opy = sr_reg; end
            5'd18:   begin opx = cy_reg;   opy = sr_reg; end
            5'd19:   begin opx = sysp_reg; opy = cr_reg; end
            5'd20:   begin opx = cp_reg;   opy = sr_reg; end
            5'd21:   begin opx = cp_reg;   opy = cr_reg; end
            default: begin opx = '0;       opy = '0;     end
        endcase
        unique case (comp_idx_reg)
            2'd0:    begin r0 = ma_reg;  r1 = mb_reg; r2 = mc_reg; rz = mc_reg; end
            2'd1:    begin r0 = md_reg;  r1 = me_reg; r2 = mf_reg; rz = mf_reg; end
            default: begin r0 = -sp_reg; r1 = mh_reg; r2 = mi_reg; rz = mi_reg; end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        launch_next   = launch_reg;
        comp_idx_next = comp_idx_reg;
        cordic_start  = 1'b0;
        sqrt_start    = 1'b0;
        mreq          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next  = ST_TRIG;
                    step_next   = '0;
                    launch_next = 1'b0;
                end
            end
            ST_TRIG:
            begin
                if (!launch_reg)
                begin
                    cordic_start = 1'b1;
                    launch_next  = 1'b1;
                end
                else if (cordic_done)
                begin
                    launch_next = 1'b0;
                    if (step_reg == 5'd2)
                    begin
                        state_next = ST_PREP;
                        step_next  = '0;
                    end
                    else
                    begin
                        step_next = step_reg + 5'd1;
                    end
                end
            end
            ST_PREP:
            begin
                if (step_reg <= 5'd7)
                begin
                    mreq.en = 1'b1;
                    mreq.a  = step_reg[0] ? fa : 44'({19'b0, POLY_C2});
                    mreq.b  = {6'b0, pwm_sel};
                end
                else if (step_reg <= 5'd21)
                begin
                    mreq.en = 1'b1;
                    mreq.a  = 44'(opx);
                    mreq.b  = 22'(opy);
                end
                if (step_reg == 5'd22)
                begin
                    state_next    = ST_COMP;
                    step_next     = '0;
                    comp_idx_next = '0;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_COMP:
            begin
                case (step_reg)
                    5'd0:
                    begin
                        mreq.en = 1'b1;
                        mreq.a  = 44'(acx_reg);
                        mreq.b  = 22'(r0);
                    end
                    5'd1:
                    begin
                        mreq.en  = 1'b1;
                        mreq.acc = 1'b1;
                        mreq.a   = 44'(acy_reg);
                        mreq.b   = 22'(r1);
                    end
                    5'd2:
                    begin
                        mreq.en  = 1'b1;
                        mreq.acc = 1'b1;
                        mreq.a   = 44'(acz_reg);
                        mreq.b   = 22'(r2);
                    end
                    5'd3:
                    begin
                        mreq.en = 1'b1;
                        mreq.a  = {27'b0, fp_w};
                        mreq.b  = 22'(rz);
                    end
                    5'd4:
                    begin
                        mreq.en = 1'b1;
                        mreq.a  = 44'(dot_reg);
                        mreq.b  = {2'b00, mass_reg};
                    end
                    default:
                    begin
                        mreq.en = 1'b0;
                    end
                endcase
                if (step_reg == 5'd5)
                begin
                    step_next = '0;
                    if (comp_idx_reg == 2'd2)
                    begin
                        state_next = ST_SQUARE;
                    end
                    else
                    begin
                        comp_idx_next = comp_idx_reg + 2'd1;
                    end
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_SQUARE:
            begin
                case (step_reg)
                    5'd0:
                    begin
                        mreq.en = 1'b1;
                        mreq.a  = {23'b0, t0_reg};
                        mreq.b  = {1'b0, t0_reg};
                    end
                    5'd1:
                    begin
                        mreq.en  = 1'b1;
                        mreq.acc = 1'b1;
                        mreq.a   = {23'b0, t1_reg};
                        mreq.b   = {1'b0, t1_reg};
                    end
                    5'd2:
                    begin
                        mreq.en  = 1'b1;
                        mreq.acc = 1'b1;
                        mreq.a   = {23'b0, t2_reg};
                        mreq.b   = {1'b0, t2_reg};
                    end
                    default:
                    begin
                        sqrt_start = 1'b1;
                    end
                endcase
                if (step_reg == 5'd3)
                begin
                    state_next = ST_ROOT;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_UPDATE;
                    step_next  = '0;
                end
            end
            ST_UPDATE:
            begin
                if (step_reg == 5'd0)
                begin
                    mreq.en = 1'b1;
                    mreq.a  = 44'(diff_w);
                    mreq.b  = {5'b0, k_w};
                end
                else if (step_reg == 5'd1)
                begin
                    mreq.en = 1'b1;
                    mreq.a  = {11'b0, pp_reg};
                    mreq.b  = {5'b0, omk_w};
                end
                if (step_reg == 5'd2)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            launch_reg    <= 1'b0;
            comp_idx_reg  <= '0;
            mass_reg      <= 20'd32191;
            qnoise_reg    <= 20'd256;
            rnoise_reg    <= 20'd102400;
            est_reg       <= '0;
            cov_reg       <= COV_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            launch_reg   <= launch_next;
            comp_idx_reg <= comp_idx_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MASS:   mass_reg   <= cfg_data;
                    CFG_QNOISE: qnoise_reg <= cfg_data;
                    CFG_RNOISE: rnoise_reg <= cfg_data;
                    default:    mass_reg   <= mass_reg;
                endcase
            end
            if (state_reg == ST_UPDATE && step_reg == 5'd1)
            begin
                est_reg <= est_new;
            end
            if (state_reg == ST_UPDATE && step_reg == 5'd2)
            begin
                cov_reg <= cov_new;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            roll_reg  <= roll_angle;
            pitch_reg <= pitch_angle;
            yaw_reg   <= yaw_angle;
            acx_reg   <= accel_x;
            acy_reg   <= accel_y;
            acz_reg   <= accel_z;
            pwm0_reg  <= pwm_motor_one;
            pwm1_reg  <= pwm_motor_two;
            pwm2_reg  <= pwm_motor_three;
            pwm3_reg  <= pwm_motor_four;
            pp_reg    <= pp_w;
            den_reg   <= den_w;
        end
        if (state_reg == ST_TRIG && launch_reg && cordic_done)
        begin
            unique case (step_reg[1:0])
                2'd0:    begin sr_reg <= cordic_sin; cr_reg <= cordic_cos; end
                2'd1:    begin sp_reg <= cordic_sin; cp_reg <= cordic_cos; end
                default: begin sy_reg <= cordic_sin; cy_reg <= cordic_cos; end
            endcase
        end
        if (state_reg == ST_PREP)
        begin
            case (step_reg)
                5'd2:  sum_reg  <= mac_acc[60:0] + POLY_C0;
                5'd4:  sum_reg  <= sum_reg + mac_acc[60:0] + POLY_C0;
                5'd6:  sum_reg  <= sum_reg + mac_acc[60:0] + POLY_C0;
                5'd8:  sum_reg  <= sum_reg + mac_acc[60:0] + POLY_C0;
                5'd9:  cysp_reg <= p16[19:0];
                5'd10: sysp_reg <= p16[19:0];
                5'd11: ma_reg   <= p16[19:0];
                5'd12: mb_reg   <= -p16[19:0];
                5'd13: mb_reg   <= mb_reg + p16[19:0];
                5'd14: mc_reg   <= p16[19:0];
                5'd15: mc_reg   <= mc_reg + p16[19:0];
                5'd16: md_reg   <= p16[19:0];
                5'd17: me_reg   <= p16[19:0];
                5'd18: me_reg   <= me_reg + p16[19:0];
                5'd19: mf_reg   <= -p16[19:0];
                5'd20: mf_reg   <= mf_reg + p16[19:0];
                5'd21: mh_reg   <= p16[19:0];
                5'd22: mi_reg   <= p16[19:0];
                default: sum_reg <= sum_reg;
            endcase
        end
        if (state_reg == ST_COMP)
        begin
            if (step_reg == 5'd3)
            begin
                dot_reg <= rnd12(mac_acc);
            end
            if (step_reg == 5'd4)
            begin
                tf_reg <= p16[29:0];
            end
            if (step_reg == 5'd5)
            begin
                unique case (comp_idx_reg)
                    2'd0:    t0_reg <= tclamp;
                    2'd1:    t1_reg <= tclamp;
                    default: t2_reg <= tclamp;
                endcase
            end
        end
        if (state_reg == ST_ROOT && sqrt_done)
        begin
            raw_reg <= lead_w[20] ? OUT_LIMIT : lead_w[19:0];
        end
        if (out_load)
        begin
            raw_out_reg  <= raw_reg;
            filt_out_reg <= est_reg;
        end
    end

    ap_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block took a request but did not raise stall");

    ap_gain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> !div_busy)
        else $error("gain divider still busy at filter update");

    ap_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && step_reg == 5'd0) |-> (k_w <= ONE_F))
        else $error("Kalman gain above one");

    ap_cordic_owner: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == ST_TRIG))
        else $error("CORDIC finished outside the trig phase");
endmodule

// File: hw/rtl/tte_mac.sv
// Shared signed multiply-accumulate unit with a registered result.
// Depends on tte_pkg for the request struct and widths.
module tte_mac (
    input  logic                               clk,
    input  tte_pkg::mac_req_t                  req,
    output logic signed [tte_pkg::MAC_P_W-1:0] acc
);
    import tte_pkg::*;

    logic signed [MAC_A_W+MAC_B_W-1:0] prod;
    logic signed [MAC_P_W-1:0]         acc_reg;

    assign prod = req.a * req.b;
    assign acc  = acc_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.acc)
            begin
                acc_reg <= acc_reg + MAC_P_W'(prod);
            end
            else
            begin
                acc_reg <= MAC_P_W'(prod);
            end
        end
    end
endmodule

// File: hw/rtl/tte_cordic.sv
// Iterative CORDIC sine/cosine, one rotation per cycle, with a half-turn fold.
// Depends on tte_pkg for the arctangent table and angle constants.
module tte_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [14:0] angle,
    output logic               done,
    output logic signed [19:0] sin_val,
    output logic signed [19:0] cos_val
);
    import tte_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [3:0]         iter_reg;
    logic signed [19:0] x_reg;
    logic signed [19:0] y_reg;
    logic signed [20:0] z_reg;
    logic               neg_reg;
    logic signed [19:0] sin_reg;
    logic signed [19:0] cos_reg;

    logic signed [20:0] a_in;
    logic signed [20:0] a_fold;
    logic               neg_fold;
    logic signed [19:0] xs;
    logic signed [19:0] ys;
    logic signed [20:0] t;
    logic signed [19:0] x_nx;
    logic signed [19:0] y_nx;
    logic signed [20:0] z_nx;

    always_comb
    begin
        a_in     = {{2{angle[14]}}, angle, 4'b0000};
        a_fold   = a_in;
        neg_fold = 1'b0;
        if (a_in > HALF_PI_F)
        begin
            a_fold   = a_in - PI_F;
            neg_fold = 1'b1;
        end
        else if (a_in < NHALF_PI_F)
        begin
            a_fold   = a_in + PI_F;
            neg_fold = 1'b1;
        end
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        t  = {5'b00000, atan_f(iter_reg)};
        if (!z_reg[20])
        begin
            x_nx = x_reg - ys;
            y_nx = y_reg + xs;
            z_nx = z_reg - t;
        end
        else
        begin
            x_nx = x_reg + ys;
            y_nx = y_reg - xs;
            z_nx = z_reg + t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 4'd1;
                if (iter_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= GAIN_F;
            y_reg   <= '0;
            z_reg   <= a_fold;
            neg_reg <= neg_fold;
        end
        else if (busy_reg)
        begin
            x_reg <= x_nx;
            y_reg <= y_nx;
            z_reg <= z_nx;
            if (iter_reg == 4'd15)
            begin
                sin_reg <= neg_reg ? -y_nx : y_nx;
                cos_reg <= neg_reg ? -x_nx : x_nx;
            end
        end
    end

    assign done    = done_reg;
    assign sin_val = sin_reg;
    assign cos_val = cos_reg;
endmodule

// File: hw/rtl/tte_sqrt.sv
// Iterative integer square root, one result bit per cycle (floor).
// Depends on tte_pkg only through the common import.
module tte_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [41:0] radicand,
    output logic        done,
    output logic [20:0] root
);
    import tte_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [41:0] n_reg;
    logic [41:0] r_reg;
    logic [41:0] bit_reg;
    logic [41:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= 42'd1 << 40;
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[20:0];
endmodule

// File: hw/rtl/tte_div.sv
// Restoring divider for the Kalman gain, one quotient bit per cycle.
// Depends on tte_pkg only through the common import.
module tte_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] num,
    input  logic [33:0] den,
    output logic        busy,
    output logic [16:0] quo
);
    import tte_pkg::*;

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [33:0] rem_reg;
    logic [33:0] dd_reg;
    logic        lsb_reg;
    logic [16:0] q_reg;
    logic        nb;
    logic [34:0] trial;
    logic        ge;

    always_comb
    begin
        nb    = (cnt_reg == 5'd16) ? lsb_reg : 1'b0;
        trial = {rem_reg, nb};
        ge    = trial >= {1'b0, dd_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd16;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {2'b00, num[32:1]};
            lsb_reg <= num[0];
            dd_reg  <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 34'(trial - {1'b0, dd_reg}) : trial[33:0];
            q_reg   <= {q_reg[15:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;
endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for tether_tension_estimator_unit: random requests, directed table,
// then random requests under random idle and stall bursts (none in the last phase), checked
// against an in-bench fixed-point model. Depends on tte_pkg and the estimator RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tte_pkg::*;

    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  PHASE_ITEMS = 200;
    localparam longint PI_Q30   = 64'sd3373259426;
    localparam longint HPI_Q30  = 64'sd1686629713;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint unsigned C2_Q60 = 64'd24560629;
    localparam longint unsigned C1_Q60 = 64'd1190544792000;
    localparam longint unsigned C0_Q60 = 64'd632326716600000;
    localparam longint ATAN_Q30 [16] = '{843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768};

    typedef struct {
        logic signed [14:0] roll, pitch, yaw;
        logic signed [20:0] ax, ay, az;
        logic [15:0]        pwm1, pwm2, pwm3, pwm4;
        bit                 fix_raw;
        logic [19:0]        raw_fixed;
    } request_t;

    typedef struct {
        logic [19:0] raw;
        logic [19:0] filt;
    } tension_t;

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    logic [14:0] roll_angle, pitch_angle, yaw_angle;
    logic [20:0] accel_x, accel_y, accel_z;
    logic [15:0] pwm_motor_one, pwm_motor_two, pwm_motor_three, pwm_motor_four;
    logic [19:0] raw_tension, filtered_tension;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;

    tension_t    tension_q[$];
    int          errors;
    int          cycles;
    bit          quiet;
    int          stall_left;
    logic [19:0] mass_reg, qnoise_reg, rnoise_reg;
    logic [19:0] est_reg;
    logic [31:0] cov_reg;

    tether_tension_estimator_unit DUT (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic longint rnd_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return rnd_shift(a * b, FRAC_BITS);
    endfunction

    task automatic cordic(input longint ang, output longint s, output longint c);
        longint pi_q, hpi_q, x, y, nx, t;
        bit     neg;
        pi_q  = rnd_shift(PI_Q30, 30 - FRAC_BITS);
        hpi_q = rnd_shift(HPI_Q30, 30 - FRAC_BITS);
        x = rnd_shift(GAIN_Q30, 30 - FRAC_BITS);
        y = 0;
        neg = 0;
        if (ang > hpi_q)
        begin
            ang -= pi_q;
            neg = 1;
        end
        else if (ang < -hpi_q)
        begin
            ang += pi_q;
            neg = 1;
        end
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            t = rnd_shift(ATAN_Q30[i], 30 - FRAC_BITS);
            if (ang >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                ang -= t;
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                ang += t;
            end
            x = nx;
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endtask

    function automatic longint unsigned motor_force(logic [15:0] p);
        longint unsigned q;
        q = p;
        return C2_Q60 * q * q + C1_Q60 * q + C0_Q60;
    endfunction

    function automatic longint tension_axis(longint r0, longint r1, longint r2, longint rz,
                                            longint fp, request_t r);
        longint dot, t;
        dot = rnd_shift(r0 * longint'(r.ax) + r1 * longint'(r.ay) + r2 * longint'(r.az), 12);
        t = qmul(rz, fp) - rnd_shift(dot * longint'(mass_reg), 20);
        if (t < 0) t = -t;
        return (t > (longint'(1) << 20)) ? (longint'(1) << 20) : t;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0)
        begin
            if (n >= res + bt)
            begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end
            else
                res >>= 1;
            bt >>= 2;
        end
        return res;
    endfunction

    task automatic predict_tension(input request_t r, output tension_t res);
        longint sr, cr, sp, cp, sy, cy, fp, cysp, sysp;
        longint a, b, c, d, e, f, g, h, i, tx, ty, tz, k, diff, est;
        longint unsigned sum, raw, pp, den, pn;
        cordic(longint'(r.roll) * 16, sr, cr);
        cordic(longint'(r.pitch) * 16, sp, cp);
        cordic(longint'(r.yaw) * 16, sy, cy);
        sum = motor_force(r.pwm1) + motor_force(r.pwm2) + motor_force(r.pwm3)
            + motor_force(r.pwm4);
        fp = longint'((sum + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
        cysp = qmul(cy, sp);
        sysp = qmul(sy, sp);
        a = qmul(cy, cp);
        b = -qmul(sy, cr) + qmul(cysp, sr);
        c = qmul(sy, sr) + qmul(cysp, cr);
        d = qmul(sy, cp);
        e = qmul(cy, cr) + qmul(sysp, sr);
        f = -qmul(cy, sr) + qmul(sysp, cr);
        g = -sp;
        h = qmul(cp, sr);
        i = qmul(cp, cr);
        tx = tension_axis(a, b, c, c, fp, r);
        ty = tension_axis(d, e, f, f, fp, r);
        tz = tension_axis(g, h, i, i, fp, r);
        raw = int_sqrt(longint'(tx * tx + ty * ty + tz * tz));
        if (raw > 64'hFFFFF) raw = 64'hFFFFF;
        pp  = longint'(cov_reg) + (longint'(qnoise_reg) << (FRAC_BITS - 8));
        den = pp + (longint'(rnoise_reg) << (FRAC_BITS - 8));
        k = (den == 0) ? 0 : longint'((pp << FRAC_BITS) / den);
        diff = longint'(raw) - longint'(est_reg);
        est = longint'(est_reg) + qmul(k, diff);
        if (est < 0) est = 0;
        if (est > 64'shFFFFF) est = 64'shFFFFF;
        est_reg = est[19:0];
        pn = (longint'((longint'(1) << FRAC_BITS) - k) * pp
              + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        cov_reg = (pn > 64'hFFFFFFFF) ? 32'hFFFFFFFF : pn[31:0];
        res.raw  = raw[19:0];
        res.filt = est_reg;
    endtask

    task automatic report_mismatch(string what, logic [19:0] want, logic [19:0] got);
        $display("mismatch %s: expected %0d, got %0d at cycle %0d", what, want, got, cycles);
        errors++;
    endtask

    // receive side: check, then pick the next stall
    always @(posedge clk)
    begin
        tension_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tension_q.size() == 0)
            begin
                $display("unexpected result %0d/%0d at cycle %0d",
                         raw_tension, filtered_tension, cycles);
                errors++;
            end
            else
            begin
                want = tension_q.pop_front();
                if (raw_tension !== want.raw)
                    report_mismatch("raw_tension", want.raw, raw_tension);
                if (filtered_tension !== want.filt)
                    report_mismatch("filtered_tension", want.filt, filtered_tension);
            end
        end
        if (stall_left > 0)
            stall_left--;
        else if (!quiet && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
        out_stall <= (stall_left > 0);
    end

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MASS:   mass_reg   = val;
            CFG_QNOISE: qnoise_reg = val;
            CFG_RNOISE: rnoise_reg = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tension_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_regs(logic [19:0] m, logic [19:0] q, logic [19:0] rn);
        drain();
        write_reg(CFG_MASS, m);
        write_reg(CFG_QNOISE, q);
        write_reg(CFG_RNOISE, rn);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(request_t r);
        tension_t res;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        roll_angle      <= r.roll;
        pitch_angle     <= r.pitch;
        yaw_angle       <= r.yaw;
        accel_x         <= r.ax;
        accel_y         <= r.ay;
        accel_z         <= r.az;
        pwm_motor_one   <= r.pwm1;
        pwm_motor_two   <= r.pwm2;
        pwm_motor_three <= r.pwm3;
        pwm_motor_four  <= r.pwm4;
        do @(posedge clk); while (in_stall);
        predict_tension(r, res);
        if (r.fix_raw) res.raw = r.raw_fixed;
        tension_q.push_back(res);
    endtask

    function automatic logic signed [14:0] pick_angle(int style);
        if (style == 2) return 15'($urandom);
        if (style == 1) return 15'($signed($urandom_range(0, 25736)) - 12868);
        return 15'($signed($urandom_range(0, 4096)) - 2048);
    endfunction

    function automatic logic signed [20:0] pick_accel(int style, int centre);
        if (style == 2) return 21'($urandom);
        if (style == 1) return 21'($signed($urandom_range(0, 1638400)) - 819200);
        return 21'($signed($urandom_range(0, 24576)) - 12288 + centre);
    endfunction

    function automatic logic [15:0] pick_pwm(int style);
        if (style == 0) return 16'($urandom_range(30000, 60000));
        return 16'($urandom);
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       style, pick;
        pick  = $urandom_range(0, 9);
        style = (pick < 6) ? 0 : (pick < 9) ? 1 : 2;
        r.roll  = pick_angle(style);
        r.pitch = pick_angle(style);
        r.yaw   = pick_angle(style);
        r.ax    = pick_accel(style, 0);
        r.ay    = pick_accel(style, 0);
        r.az    = pick_accel(style, 40181);
        r.pwm1  = pick_pwm(style);
        r.pwm2  = pick_pwm(style);
        r.pwm3  = pick_pwm(style);
        r.pwm4  = pick_pwm(style);
        r.fix_raw   = 0;
        r.raw_fixed = '0;
        return r;
    endfunction

    request_t directed [] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 819200, 819200, 819200, 0, 0, 0, 0, 1, 20'hFFFFF},
        '{0, 0, 0, -819200, -819200, -819200, 65535, 65535, 65535, 65535, 1, 20'hFFFFF},
        '{12868, 12868, 12868, 0, 0, 40181, 65535, 65535, 65535, 65535, 0, 0},
        '{-12868, -12868, -12868, 0, 0, 40181, 0, 0, 0, 0, 0, 0},
        '{16383, -16384, 16383, 1048575, -1048576, 0, 1, 2, 4, 8, 0, 0},
        '{-16384, 16383, -16384, -1048576, 1048575, 1048575, 65535, 0, 65535, 0, 0, 0},
        '{6434, -6434, 6435, 4096, -4096, 40181, 40000, 41000, 42000, 43000, 0, 0},
        '{12867, 6433, -12867, 100, 200, 300, 32768, 16384, 8192, 21845, 0, 0},
        '{0, 0, 0, 0, 0, 40181, 43690, 43690, 43690, 43690, 0, 0},
        '{1, -1, 1, 1, -1, 1, 1, 1, 1, 1, 0, 0},
        '{-8192, 8191, 4096, 819200, -819200, 409600, 50000, 50000, 50000, 50000, 0, 0}
    };

    initial
    begin
        errors = 0;
        cycles = 0;
        quiet = 0;
        stall_left = 0;
        rst_n = 0;
        in_valid = 0;
        out_stall = 0;
        cfg_valid = 0;
        cfg_index = CFG_MASS;
        cfg_data = '0;
        {roll_angle, pitch_angle, yaw_angle} = '0;
        {accel_x, accel_y, accel_z} = '0;
        {pwm_motor_one, pwm_motor_two, pwm_motor_three, pwm_motor_four} = '0;
        mass_reg = 20'd32191;
        qnoise_reg = 20'd256;
        rnoise_reg = 20'd102400;
        est_reg = '0;
        cov_reg = COV_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < 8; n++)
            send_request(random_request());

        set_regs(20'hFFFFF, 20'd0, 20'd1);
        foreach (directed[n])
            send_request(directed[n]);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_regs(20'd0, 20'hFFFFF, 20'hFFFFF);
                1: set_regs(20'd32191, 20'd256, 20'd102400);
                2: set_regs(20'd40000, 20'd0, 20'd0);
                7:
                begin
                    set_regs(20'd32191, 20'd256, 20'd102400);
                    quiet = 1;
                end
                default: set_regs(20'($urandom), 20'($urandom_range(0, 4096)),
                                  20'($urandom_range(1, 1048575)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 4 && n == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    while (tension_q.size() != 0) @(posedge clk);
                end
                send_request(random_request());
            end
        end
        in_valid <= 1'b0;

        while (tension_q.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
